/* hdl/pse_pkg.sv */
package pse_pkg;

  localparam int COORD_W         = 24;
  localparam int COORD_FRAC_BITS = 12;
  localparam int CORDIC_N        = 16;
  localparam int PRESHIFT        = 14;
  localparam int HW_W            = 12;
  localparam int VEC_W           = COORD_W + 1;
  localparam int XW              = VEC_W + PRESHIFT + 3;
  localparam int ANG_W           = 32;
  localparam int CROSS_W         = 2 * VEC_W + 1;
  localparam int UP_SH           = (COORD_FRAC_BITS > 12) ? COORD_FRAC_BITS - 12 : 0;
  localparam int DN_SH           = (COORD_FRAC_BITS < 12) ? 12 - COORD_FRAC_BITS : 0;
  localparam int NUM_W           = XW + HW_W + 1 + UP_SH;
  localparam int DVD_W           = NUM_W + 1;
  localparam int DEN_W           = XW + DN_SH;
  localparam int Q_W             = 26;
  localparam int CNT_W           = $clog2(DVD_W);
  localparam int SUM_W           = Q_W + 2;

  localparam logic [HW_W-1:0]  HW_RESET     = 12'd696;
  localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic             OP_CLEAR     = 1'b1;

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [VEC_W-1:0]     vec_t;
  typedef logic signed [XW-1:0]        xw_t;
  typedef logic signed [2*VEC_W-1:0]   prod_t;
  typedef logic signed [CROSS_W-1:0]   cross_t;
  typedef logic signed [NUM_W-1:0]     num_t;
  typedef logic [DVD_W-1:0]            dvd_t;
  typedef logic [DEN_W-1:0]            den_t;
  typedef logic [Q_W-1:0]              quo_t;
  typedef logic signed [Q_W:0]         off_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [ANG_W+1:0]     zang_t;

  localparam cross_t CROSS_HALF = cross_t'(1) <<< (2 * COORD_FRAC_BITS - 1);

  typedef struct packed {
    coord_t last_x;
    coord_t last_y;
    vec_t   ax;
    vec_t   ay;
    vec_t   bx;
    vec_t   by;
    logic   degen;
  } job_t;

  typedef enum logic {
    CM_VECTOR,
    CM_ROTATE
  } cmode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CROSS1,
    S_CROSS2,
    S_VEC1,
    S_VEC2,
    S_ROT,
    S_MULX,
    S_DSX,
    S_DIVX,
    S_MULY,
    S_DSY,
    S_DIVY,
    S_DONE
  } back_state_e;

  function automatic logic [ANG_W-1:0] atan_val(input logic [4:0] idx);
    logic [ANG_W-1:0] r;
    unique case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic coord_t sat_coord(input sum_t v);
    coord_t r;
    if (v > sum_t'(coord_t'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < sum_t'(coord_t'({1'b1, {(COORD_W-1){1'b0}}}))) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/pse_if.sv */
interface pse_pt_if;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic signed [23:0]     point_x;
  logic signed [23:0]     point_y;

  modport source (output valid, operation, point_x, point_y, input ready);
  modport sink   (input valid, operation, point_x, point_y, output ready);
endinterface

interface pse_vtx_if;
  logic                   valid;
  logic                   ready;
  logic signed [23:0]     left_x;
  logic signed [23:0]     left_y;
  logic signed [23:0]     right_x;
  logic signed [23:0]     right_y;
  logic                   degenerate;

  modport source (output valid, left_x, left_y, right_x, right_y, degenerate, input ready);
  modport sink   (input valid, left_x, left_y, right_x, right_y, degenerate, output ready);
endinterface

/* hdl/polyline_stroke_extruder.sv */
// channel   dir  handshake      word
// pt_i      in   valid/ready    operation, point_x, point_y
// vtx_o     out  valid/ready    left_x, left_y, right_x, right_y, degenerate
// cfg       in   cfg_we_i       half_width (cfg_data_i)
//
// a non-degenerate add that yields vertices runs the shared one-step-per-cycle cordic three
// times and the bit-serial divider twice
// clear and the first two adds yield no vertex word; a two-entry queue holds pending words
// rst_ni clears the point count, history, queue and output valid; half_width resets to 0.17
// a stalled output holds its word while up to two further words queue up

module polyline_stroke_extruder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pse_pkg::HW_W-1:0]  cfg_data_i,
  pse_pt_if.sink                    pt_i,
  pse_vtx_if.source                 vtx_o
);

  logic [pse_pkg::HW_W-1:0] hw_q;
  pse_pkg::job_t            push_job, pop_job;
  logic                     push, full, pop, fvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= pse_pkg::HW_RESET;
    end else if (cfg_we_i) begin
      hw_q <= cfg_data_i;
    end
  end

  pse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  pse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fvalid),
    .job_o   (pop_job)
  );

  pse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fvalid),
    .job_i   (pop_job),
    .pop_o   (pop),
    .hw_i    (hw_q),
    .vtx_o   (vtx_o)
  );

endmodule

/* hdl/pse_front.sv */
module pse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pse_pt_if.sink        pt_i,
  input  logic          full_i,
  output logic          push_o,
  output pse_pkg::job_t job_o
);

  logic [1:0]      count_q, count_d;
  pse_pkg::coord_t last_x_q, last_y_q, bl_x_q, bl_y_q;
  logic            accept;

  assign pt_i.ready = !full_i;
  assign accept     = pt_i.valid && !full_i;

  // history differences
  always_comb begin
    job_o.last_x = last_x_q;
    job_o.last_y = last_y_q;
    job_o.ax     = pse_pkg::vec_t'(bl_x_q) - pse_pkg::vec_t'(last_x_q);
    job_o.ay     = pse_pkg::vec_t'(bl_y_q) - pse_pkg::vec_t'(last_y_q);
    job_o.bx     = pse_pkg::vec_t'(pt_i.point_x) - pse_pkg::vec_t'(last_x_q);
    job_o.by     = pse_pkg::vec_t'(pt_i.point_y) - pse_pkg::vec_t'(last_y_q);
    job_o.degen  = ((job_o.ax == '0) && (job_o.ay == '0)) ||
                   ((job_o.bx == '0) && (job_o.by == '0));
  end

  assign push_o = accept && (pt_i.operation != pse_pkg::OP_CLEAR) && (count_q == 2'd2);

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (pt_i.operation == pse_pkg::OP_CLEAR) begin
        count_d = 2'd0;
      end else if (count_q != 2'd2) begin
        count_d = count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      last_x_q <= '0;
      last_y_q <= '0;
      bl_x_q   <= '0;
      bl_y_q   <= '0;
    end else begin
      count_q <= count_d;
      if (accept && (pt_i.operation != pse_pkg::OP_CLEAR)) begin
        last_x_q <= pt_i.point_x;
        last_y_q <= pt_i.point_y;
        if (count_q != 2'd0) begin
          bl_x_q <= last_x_q;
          bl_y_q <= last_y_q;
        end
      end
    end
  end

endmodule

/* hdl/pse_fifo.sv */
module pse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pse_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pse_pkg::job_t job_o
);

  pse_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* hdl/pse_cordic.sv */
module pse_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  pse_pkg::cmode_e             mode_i,
  input  pse_pkg::xw_t                x_i,
  input  pse_pkg::xw_t                y_i,
  input  logic [pse_pkg::ANG_W-1:0]   ang_i,
  output pse_pkg::xw_t                x_o,
  output pse_pkg::xw_t                y_o,
  output logic [pse_pkg::ANG_W-1:0]   z_o,
  output logic                        done_o
);

  pse_pkg::xw_t    x_q, y_q, sx, sy;
  pse_pkg::zang_t  z_q, zs, zalt, at;
  pse_pkg::cmode_e mode_q;
  logic [4:0]      i_q;
  logic            busy_q, done_q, ccw, last;

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q[pse_pkg::ANG_W-1:0];
  assign done_o = done_q;

  assign zs   = pse_pkg::zang_t'($signed(ang_i));
  assign zalt = pse_pkg::zang_t'($signed(ang_i + pse_pkg::HALF_TURN));
  assign sx   = x_q >>> i_q;
  assign sy   = y_q >>> i_q;
  assign at   = pse_pkg::zang_t'({2'b00, pse_pkg::atan_val(i_q)});
  assign ccw  = (mode_q == pse_pkg::CM_VECTOR) ? y_q[pse_pkg::XW-1] : !z_q[pse_pkg::ANG_W+1];
  assign last = (i_q == 5'(pse_pkg::CORDIC_N - 1));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      if (mode_i == pse_pkg::CM_VECTOR) begin
        if (x_i[pse_pkg::XW-1]) begin
          x_q <= -x_i;
          y_q <= -y_i;
          z_q <= pse_pkg::zang_t'({2'b00, pse_pkg::HALF_TURN});
        end else begin
          x_q <= x_i;
          y_q <= y_i;
          z_q <= '0;
        end
      end else begin
        if ((zs > pse_pkg::zang_t'({2'b00, pse_pkg::QUARTER_TURN})) ||
            (zs < -pse_pkg::zang_t'({2'b00, pse_pkg::QUARTER_TURN}))) begin
          x_q <= -x_i;
          y_q <= -y_i;
          z_q <= zalt;
        end else begin
          x_q <= x_i;
          y_q <= y_i;
          z_q <= zs;
        end
      end
    end else if (busy_q) begin
      if (ccw) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        i_q <= i_q + 5'd1;
      end
    end
  end

endmodule

/* hdl/pse_div.sv */
module pse_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pse_pkg::dvd_t dvd_i,
  input  pse_pkg::den_t den_i,
  output pse_pkg::quo_t q_o,
  output logic          done_o
);

  pse_pkg::dvd_t              dvd_q;
  pse_pkg::den_t              den_q, rem_q;
  pse_pkg::quo_t              q_q;
  logic [pse_pkg::CNT_W-1:0]  cnt_q;
  logic                       busy_q, done_q, fits;
  logic [pse_pkg::DEN_W:0]    trial;

  assign q_o    = q_q;
  assign done_o = done_q;
  assign trial  = {rem_q, dvd_q[pse_pkg::DVD_W-1]};
  assign fits   = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (fits) begin
        rem_q <= pse_pkg::DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[pse_pkg::DEN_W-1:0];
      end
      q_q <= {q_q[pse_pkg::Q_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pse_pkg::CNT_W'(pse_pkg::DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/pse_back.sv */
module pse_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  pse_pkg::job_t             job_i,
  output logic                      pop_o,
  input  logic [pse_pkg::HW_W-1:0]  hw_i,
  pse_vtx_if.source                 vtx_o
);

  pse_pkg::back_state_e      state_q, state_d;
  pse_pkg::job_t             job_q;
  pse_pkg::prod_t            prod_q;
  pse_pkg::cross_t           cross_q;
  logic [pse_pkg::ANG_W-1:0] phi1_q, d, delta;
  logic [pse_pkg::ANG_W:0]   theta;
  pse_pkg::xw_t              m_q, rx_q, ry_q, ax_s, ay_s, bx_s, by_s, c_x, c_y, c_xo, c_yo;
  pse_pkg::num_t             num_q, mag;
  pse_pkg::off_t             ox_q, oy_q, off;
  pse_pkg::sum_t             lx, ly;
  pse_pkg::dvd_t             dvd;
  pse_pkg::den_t             den;
  pse_pkg::quo_t             q;
  pse_pkg::cmode_e           c_mode;
  logic [pse_pkg::ANG_W-1:0] c_ang, c_z;
  logic                      c_start, c_done, d_start, d_done, m_pos, pos, neg, out_free;
  logic                      vld_q;

  assign ax_s = pse_pkg::xw_t'(job_q.ax) <<< pse_pkg::PRESHIFT;
  assign ay_s = pse_pkg::xw_t'(job_q.ay) <<< pse_pkg::PRESHIFT;
  assign bx_s = pse_pkg::xw_t'(job_q.bx) <<< pse_pkg::PRESHIFT;
  assign by_s = pse_pkg::xw_t'(job_q.by) <<< pse_pkg::PRESHIFT;

  // turn direction and rotation angle
  assign pos   = (cross_q >= pse_pkg::CROSS_HALF);
  assign neg   = (cross_q <= -pse_pkg::CROSS_HALF);
  assign d     = c_z - phi1_q;
  assign theta = d[pse_pkg::ANG_W-1] ? (pse_pkg::ANG_W+1)'(-$signed({1'b1, d})) : {1'b0, d};
  assign delta = pos ? theta[pse_pkg::ANG_W:1] :
                 neg ? (pse_pkg::HALF_TURN - theta[pse_pkg::ANG_W:1]) : pse_pkg::QUARTER_TURN;

  assign m_pos = (m_q > '0);
  assign mag   = num_q[pse_pkg::NUM_W-1] ? -num_q : num_q;
  assign dvd   = (pse_pkg::dvd_t'(mag) << 1) + pse_pkg::dvd_t'(m_q);
  assign den   = pse_pkg::den_t'(m_q) << (pse_pkg::DN_SH + 1);
  assign off   = num_q[pse_pkg::NUM_W-1] ? -pse_pkg::off_t'({1'b0, q}) :
                                           pse_pkg::off_t'({1'b0, q});

  assign lx = pse_pkg::sum_t'(job_q.last_x);
  assign ly = pse_pkg::sum_t'(job_q.last_y);
  assign out_free = !vld_q || vtx_o.ready;
  assign vtx_o.valid = vld_q;

  pse_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c_start),
    .mode_i  (c_mode),
    .x_i     (c_x),
    .y_i     (c_y),
    .ang_i   (c_ang),
    .x_o     (c_xo),
    .y_o     (c_yo),
    .z_o     (c_z),
    .done_o  (c_done)
  );

  pse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (d_start),
    .dvd_i   (dvd),
    .den_i   (den),
    .q_o     (q),
    .done_o  (d_done)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::S_IDLE:   if (valid_i) begin
        state_d = job_i.degen ? pse_pkg::S_DONE : pse_pkg::S_CROSS1;
      end
      pse_pkg::S_CROSS1: state_d = pse_pkg::S_CROSS2;
      pse_pkg::S_CROSS2: state_d = pse_pkg::S_VEC1;
      pse_pkg::S_VEC1:   if (c_done) state_d = pse_pkg::S_VEC2;
      pse_pkg::S_VEC2:   if (c_done) state_d = pse_pkg::S_ROT;
      pse_pkg::S_ROT:    if (c_done) state_d = pse_pkg::S_MULX;
      pse_pkg::S_MULX:   state_d = pse_pkg::S_DSX;
      pse_pkg::S_DSX:    state_d = pse_pkg::S_DIVX;
      pse_pkg::S_DIVX:   if (d_done) state_d = pse_pkg::S_MULY;
      pse_pkg::S_MULY:   state_d = pse_pkg::S_DSY;
      pse_pkg::S_DSY:    state_d = pse_pkg::S_DIVY;
      pse_pkg::S_DIVY:   if (d_done) state_d = pse_pkg::S_DONE;
      pse_pkg::S_DONE:   if (out_free) state_d = pse_pkg::S_IDLE;
      default:           state_d = pse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    c_start = 1'b0;
    c_mode  = pse_pkg::CM_VECTOR;
    c_x     = ax_s;
    c_y     = ay_s;
    c_ang   = delta;
    d_start = 1'b0;
    unique case (state_q)
      pse_pkg::S_IDLE:   pop_o = valid_i;
      pse_pkg::S_CROSS2: c_start = 1'b1;
      pse_pkg::S_VEC1: begin
        c_start = c_done;
        c_x     = bx_s;
        c_y     = by_s;
      end
      pse_pkg::S_VEC2: begin
        c_start = c_done;
        c_mode  = pse_pkg::CM_ROTATE;
        c_x     = bx_s;
        c_y     = by_s;
      end
      pse_pkg::S_DSX,
      pse_pkg::S_DSY:    d_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pse_pkg::S_IDLE: begin
        job_q <= job_i;
        ox_q  <= '0;
        oy_q  <= '0;
      end
      pse_pkg::S_CROSS1: prod_q  <= pse_pkg::prod_t'(job_q.ax) * pse_pkg::prod_t'(job_q.by);
      pse_pkg::S_CROSS2: cross_q <= pse_pkg::cross_t'(prod_q) -
                                    pse_pkg::cross_t'(pse_pkg::prod_t'(job_q.ay) *
                                                      pse_pkg::prod_t'(job_q.bx));
      pse_pkg::S_VEC1:   if (c_done) phi1_q <= c_z;
      pse_pkg::S_VEC2:   if (c_done) m_q <= c_xo;
      pse_pkg::S_ROT: if (c_done) begin
        rx_q <= c_xo;
        ry_q <= c_yo;
      end
      pse_pkg::S_MULX:   num_q <= (pse_pkg::num_t'(rx_q) *
                                   pse_pkg::num_t'($signed({1'b0, hw_i}))) <<< pse_pkg::UP_SH;
      pse_pkg::S_DIVX:   if (d_done) ox_q <= m_pos ? off : '0;
      pse_pkg::S_MULY:   num_q <= (pse_pkg::num_t'(ry_q) *
                                   pse_pkg::num_t'($signed({1'b0, hw_i}))) <<< pse_pkg::UP_SH;
      pse_pkg::S_DIVY:   if (d_done) oy_q <= m_pos ? off : '0;
      pse_pkg::S_DONE: if (out_free) begin
        vtx_o.left_x     <= pse_pkg::sat_coord(lx + pse_pkg::sum_t'(ox_q));
        vtx_o.left_y     <= pse_pkg::sat_coord(ly + pse_pkg::sum_t'(oy_q));
        vtx_o.right_x    <= pse_pkg::sat_coord(lx - pse_pkg::sum_t'(ox_q));
        vtx_o.right_y    <= pse_pkg::sat_coord(ly - pse_pkg::sum_t'(oy_q));
        vtx_o.degenerate <= job_q.degen;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == pse_pkg::S_DONE) && out_free) begin
        vld_q <= 1'b1;
      end else if (vtx_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

endmodule

/* hdl/pse_checker.sv */
module pse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [23:0] left_x_i,
  input logic signed [23:0] left_y_i,
  input logic signed [23:0] right_x_i,
  input logic signed [23:0] right_y_i,
  input logic               degenerate_i
);

  // nothing leaves while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_x_i) && $stable(right_y_i))
    else $error("stalled output word changed");

  // zero-length segment collapses both vertices onto the last point
  a_degen_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> (left_x_i == right_x_i) && (left_y_i == right_y_i))
    else $error("degenerate word with distinct vertices");

endmodule

bind polyline_stroke_extruder pse_checker u_pse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (vtx_o.valid),
  .out_ready_i  (vtx_o.ready),
  .left_x_i     (vtx_o.left_x),
  .left_y_i     (vtx_o.left_y),
  .right_x_i    (vtx_o.right_x),
  .right_y_i    (vtx_o.right_y),
  .degenerate_i (vtx_o.degenerate)
);

/* tb/pse_tb_if.sv */
`timescale 1ns / 100ps

// clock generator: nothing beyond the block's own interfaces is needed
module pse_tb_clkgen (
  output logic clk_o
);
  initial clk_o = 1'b0;
  always begin
    #1 clk_o = 1'b1;
    #1 clk_o = 1'b0;
  end
endmodule

/* tb/pse_checker.sv */
`timescale 1ns / 100ps

module pse_tb_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pse_pkg::HW_W-1:0] cfg_data_i,
  pse_pt_if.sink                   pt_i,
  pse_vtx_if.sink                  vtx_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       vertex_count_o,
  output int                       degen_count_o
);

  typedef struct packed {
    pse_pkg::coord_t lx;
    pse_pkg::coord_t ly;
    pse_pkg::coord_t rx;
    pse_pkg::coord_t ry;
    logic            degen;
  } vertex_t;

  localparam logic [31:0] ATAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  vertex_t     vertex_q[$];
  logic [11:0] width_q;
  logic [1:0]  held;
  longint      lst_x, lst_y, prv_x, prv_y;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap32(logic [31:0] u);
    return u[31] ? longint'(u) - 64'sd4294967296 : longint'(u);
  endfunction

  function automatic logic [31:0] angle_of(longint x, longint y, output longint len);
    logic [31:0] z;
    longint nx, ny;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = pse_pkg::HALF_TURN;
    end
    for (int i = 0; i < pse_pkg::CORDIC_N; i++) begin
      if (y < 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); z = z - ATAN[i];
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); z = z + ATAN[i];
      end
      x = nx; y = ny;
    end
    len = x;
    return z;
  endfunction

  task automatic turn_by(inout longint x, inout longint y, input logic [31:0] ang);
    longint z, nx, ny;
    z = wrap32(ang);
    if (z > 64'sh40000000 || z < -64'sh40000000) begin
      x = -x; y = -y;
      z = wrap32(ang + pse_pkg::HALF_TURN);
    end
    for (int i = 0; i < pse_pkg::CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); z = z - longint'(ATAN[i]);
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); z = z + longint'(ATAN[i]);
      end
      x = nx; y = ny;
    end
  endtask

  function automatic longint width_scaled(longint r, longint m);
    longint num, mag;
    num = r * longint'(width_q);
    if (m <= 0) return 0;
    mag = num < 0 ? -num : num;
    mag = (2 * mag + m) / (2 * m);
    return num < 0 ? -mag : mag;
  endfunction

  function automatic pse_pkg::coord_t clip(longint v);
    if (v > 64'sd8388607) return pse_pkg::coord_t'(24'sh7FFFFF);
    if (v < -64'sd8388608) return pse_pkg::coord_t'(24'sh800000);
    return pse_pkg::coord_t'(v);
  endfunction

  task automatic extrude(input logic op, input pse_pkg::coord_t px,
                         input pse_pkg::coord_t py);
    longint ax, ay, bx, by, cr, m1, m2, d, rx, ry, ox, oy;
    logic [31:0] p1, p2, a, delta;
    vertex_t v;
    if (op == pse_pkg::OP_CLEAR) begin
      held = 2'd0;
      return;
    end
    if (held != 2'd2) begin
      if (held == 2'd1) begin
        prv_x = lst_x; prv_y = lst_y;
      end
      lst_x = px; lst_y = py; held = held + 2'd1;
      return;
    end
    ax = prv_x - lst_x; ay = prv_y - lst_y;
    bx = longint'(px) - lst_x; by = longint'(py) - lst_y;
    v.degen = (ax == 0 && ay == 0) || (bx == 0 && by == 0);
    ox = 0; oy = 0;
    if (!v.degen) begin
      cr = ax * by - ay * bx;
      p1 = angle_of(ax <<< pse_pkg::PRESHIFT, ay <<< pse_pkg::PRESHIFT, m1);
      p2 = angle_of(bx <<< pse_pkg::PRESHIFT, by <<< pse_pkg::PRESHIFT, m2);
      d = wrap32(p2 - p1);
      if (d < 0) d = -d;
      a = 32'(d >>> 1);
      if (cr >= 64'sd8388608) delta = a;
      else if (cr <= -64'sd8388608) delta = pse_pkg::HALF_TURN - a;
      else delta = pse_pkg::QUARTER_TURN;
      rx = bx <<< pse_pkg::PRESHIFT; ry = by <<< pse_pkg::PRESHIFT;
      turn_by(rx, ry, delta);
      ox = width_scaled(rx, m2);
      oy = width_scaled(ry, m2);
    end
    v.lx = clip(lst_x + ox); v.ly = clip(lst_y + oy);
    v.rx = clip(lst_x - ox); v.ry = clip(lst_y - oy);
    vertex_q = {vertex_q, v};
    prv_x = lst_x; prv_y = lst_y;
    lst_x = px; lst_y = py;
  endtask

  task automatic compare(input string name, input pse_pkg::coord_t exp_v,
                         input pse_pkg::coord_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    if (!rst_ni) begin
      width_q = pse_pkg::HW_RESET;
      held = 2'd0;
      lst_x = 0; lst_y = 0; prv_x = 0; prv_y = 0;
      vertex_q.delete();
      fail_count_o = 0; vertex_count_o = 0; degen_count_o = 0;
    end else begin
      if (vtx_i.valid && vtx_i.ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex word with nothing expected");
          fail_count_o++;
        end else begin
          e = vertex_q.pop_front();
          compare("left_x", e.lx, vtx_i.left_x);
          compare("left_y", e.ly, vtx_i.left_y);
          compare("right_x", e.rx, vtx_i.right_x);
          compare("right_y", e.ry, vtx_i.right_y);
          if (e.degen !== vtx_i.degenerate) begin
            $error("degenerate: expected %0d, got %0d", e.degen, vtx_i.degenerate);
            fail_count_o++;
          end
          vertex_count_o++;
          if (e.degen) degen_count_o++;
        end
      end
      if (pt_i.valid && pt_i.ready) extrude(pt_i.operation, pt_i.point_x, pt_i.point_y);
      if (cfg_we_i) width_q = cfg_data_i;
    end
    pending_o = vertex_q.size();
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT = 20000;

  logic                     clk, rst_n, cfg_we;
  logic [pse_pkg::HW_W-1:0] cfg_data;
  int                       fails, pending, vertices, degens, idle_cycles, points_sent;
  bit                       stall_mode;
  logic [3:0]               stall_pat;

  pse_pt_if  pt_if ();
  pse_vtx_if vtx_if ();

  pse_tb_clkgen u_clk (.clk_o(clk));

  polyline_stroke_extruder u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .pt_i(pt_if.sink), .vtx_o(vtx_if.source)
  );

  pse_tb_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .pt_i(pt_if.sink), .vtx_i(vtx_if.sink), .fail_count_o(fails),
    .pending_o(pending), .vertex_count_o(vertices), .degen_count_o(degens)
  );

  // receiver stall pattern
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      vtx_if.ready <= 1'b0;
      stall_pat <= 4'b1011;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      stall_pat <= {stall_pat[2:0], stall_pat[3] ^ stall_pat[2]};
      vtx_if.ready <= stall_mode ? 1'b1 : stall_pat[0] | stall_pat[1];
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (pt_if.valid && pt_if.ready) || (vtx_if.valid && vtx_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("polyline_stroke_extruder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic op, input logic [23:0] px, input logic [23:0] py);
    pt_if.valid <= 1'b1;
    pt_if.operation <= op;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    do @(posedge clk); while (!pt_if.ready);
    points_sent++;
    if ($urandom_range(0, 3) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_width(input logic [pse_pkg::HW_W-1:0] w);
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] rnd_coord(input int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      default: return 24'($signed($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  initial begin
    logic [23:0] x0, y0;
    int          mode;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    stall_mode = 1'b1;
    points_sent = 0;
    x0 = '0;
    y0 = '0;
    pt_if.valid = 1'b0;
    pt_if.operation = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: turns, straight runs, zero-length segments, extremes, clear
    send(1'b0, 24'd0, 24'd0);
    send(1'b0, 24'd4096, 24'd0);
    send(1'b0, 24'd8192, 24'd4096);
    send(1'b0, 24'd8192, 24'd8192);
    send(1'b0, 24'd12288, 24'd8192);
    send(1'b0, 24'd16384, 24'd8192);
    send(1'b0, 24'd16384, 24'd8192);
    send(1'b0, 24'd16385, 24'd8193);
    send(1'b0, 24'h7FFFFF, 24'h7FFFFF);
    send(1'b0, 24'h800000, 24'h800000);
    send(1'b0, 24'h7FFFFF, 24'h800000);
    send(1'b0, 24'h800000, 24'h7FFFFF);
    send(1'b1, 24'h555555, 24'hAAAAAA);
    send(1'b0, 24'd100, 24'd100);
    send(1'b0, 24'd100, 24'd100);
    send(1'b0, 24'd200, 24'd300);
    send(1'b0, 24'd1, 24'd0);
    send(1'b0, 24'd2, 24'd0);
    send(1'b0, 24'd3, 24'd1);
    drain();

    write_width(12'd0);
    send(1'b0, 24'd0, 24'd0);
    send(1'b0, 24'd4096, 24'd0);
    send(1'b0, 24'd4096, 24'd4096);
    drain();
    write_width(12'hFFF);
    send(1'b0, 24'h7FF000, 24'd0);
    send(1'b0, 24'h7FFFFF, 24'd0);
    send(1'b0, 24'h7FFFFF, 24'd4096);
    drain();

    // random polylines in phases with different widths
    for (int ph = 0; ph < 6; ph++) begin
      write_width(ph == 5 ? pse_pkg::HW_RESET : 12'($urandom));
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          send(1'b1, rnd_coord(0), rnd_coord(0));
        end else begin
          mode = $urandom_range(0, 4);
          if (mode == 4 && k > 0) begin
            send(1'b0, x0, y0);
          end else begin
            x0 = (mode == 0) ? rnd_coord(0) : x0 + rnd_coord(mode > 2 ? 2 : mode);
            y0 = (mode == 0) ? rnd_coord(0) : y0 + rnd_coord(mode > 2 ? 2 : mode);
            send(1'b0, x0, y0);
          end
        end
      end
      drain();
    end

    $display("run covered %0d point words, %0d vertex words, %0d degenerate",
             points_sent, vertices, degens);
    if (fails == 0) begin
      $display("polyline_stroke_extruder regression: pass");
    end else begin
      $display("polyline_stroke_extruder regression: fail");
    end
    $finish;
  end
endmodule

/* polyline_stroke_extruder.f */
hdl/pse_pkg.sv
hdl/pse_if.sv
hdl/pse_front.sv
hdl/pse_fifo.sv
hdl/pse_cordic.sv
hdl/pse_div.sv
hdl/pse_back.sv
hdl/polyline_stroke_extruder.sv
hdl/pse_checker.sv
tb/pse_tb_if.sv
tb/pse_checker.sv
tb/testbench.sv
